@@ src/sbqeq_pkg.sv @@
// ----------------------------------------------------------------------------
// sbqeq_pkg
// Shared sizes, codes and types of the stereo biquad cascade equaliser.
// ----------------------------------------------------------------------------
package sbqeq_pkg;

   localparam int NUM_BANDS      = 5;
   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 23;

   localparam int COEF_BITS = COEF_FRAC_BITS + 4;
   localparam int NCOEF     = 5;
   localparam int MASK_BITS = 5;

   localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int BCNT_W = $clog2(NUM_BANDS + 1);
   localparam int TAP_W  = 3;

   // product of one coefficient and one sample, and the sum of five of them
   localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam int QNT_W  = ACC_W - COEF_FRAC_BITS;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_EQ_ENABLE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_MASK = 4'd1;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_COEF   = 2'd1,
      MODE_CLEAR  = 2'd2
   } sbqeq_mode_type;

   // coefficient slots, also the order in which the taps are multiplied
   localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
   localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
   localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
   localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
   localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEL,
      S_MAC,
      S_DRAIN,
      S_WB
   } sbqeq_state_type;

   typedef struct packed {
      logic              load;
      logic              acc_en;
      logic              acc_first;
      logic              acc_sub;
      logic              wb;
      logic              clr_all;
      logic              clr_band;
      logic [BAND_W-1:0] band;
      logic [TAP_W-1:0]  tap;
   } sbqeq_lane_ctrl_type;

endpackage

@@ src/sbqeq_req_if.sv @@
// ----------------------------------------------------------------------------
// sbqeq_req_if
// Request channel: stereo samples, coefficient writes and history clears.
// ----------------------------------------------------------------------------
interface sbqeq_req_if;
   import sbqeq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   logic [2:0]                    band_index;
   logic [2:0]                    coef_select;
   logic signed [COEF_BITS-1:0]   coef_value;

   modport source (
      output valid, mode, left_in, right_in, band_index, coef_select, coef_value,
      input  ready
   );
   modport sink (
      input  valid, mode, left_in, right_in, band_index, coef_select, coef_value,
      output ready
   );
endinterface

@@ src/sbqeq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sbqeq_rsp_if
// Response channel: one equalised stereo pair per sample item.
// ----------------------------------------------------------------------------
interface sbqeq_rsp_if;
   import sbqeq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

@@ src/sbqeq_csr_if.sv @@
// ----------------------------------------------------------------------------
// sbqeq_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sbqeq_csr_if;
   import sbqeq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ src/sbqeq_lane.sv @@
// ----------------------------------------------------------------------------
// sbqeq_lane
// One channel of the cascade: a multiply-accumulate unit stepped over the
// five taps of the current band, and the x/y history of every band.
// ----------------------------------------------------------------------------
module sbqeq_lane (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sbqeq_pkg::sbqeq_lane_ctrl_type          ctrl,
   input  logic signed [sbqeq_pkg::SAMPLE_BITS-1:0] sample_in,
   input  logic signed [sbqeq_pkg::COEF_BITS-1:0]   coef,
   output logic signed [sbqeq_pkg::SAMPLE_BITS-1:0] sample_out
);
   import sbqeq_pkg::*;

   logic signed [SAMPLE_BITS-1:0] x_cur_ff, x_cur_in;
   logic signed [SAMPLE_BITS-1:0] xh1_ff [NUM_BANDS];
   logic signed [SAMPLE_BITS-1:0] xh2_ff [NUM_BANDS];
   logic signed [SAMPLE_BITS-1:0] yh1_ff [NUM_BANDS];
   logic signed [SAMPLE_BITS-1:0] yh2_ff [NUM_BANDS];
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;

   logic signed [SAMPLE_BITS-1:0] operand;
   logic signed [ACC_W-1:0]       addend;
   logic signed [ACC_W-1:0]       base;
   logic signed [QNT_W-1:0]       qnt;
   logic                          ovf;
   logic signed [SAMPLE_BITS-1:0] y_sat;

   // pick the operand of the tap being multiplied this cycle
   always_comb begin
      case (ctrl.tap)
         TAP_B0:  operand = x_cur_ff;
         TAP_B1:  operand = xh1_ff[ctrl.band];
         TAP_B2:  operand = xh2_ff[ctrl.band];
         TAP_A1:  operand = yh1_ff[ctrl.band];
         TAP_A2:  operand = yh2_ff[ctrl.band];
         default: operand = '0;
      endcase
   end

   assign prod_in = coef * operand;

   always_comb begin
      addend = ACC_W'(prod_ff);
      base   = ctrl.acc_first ? '0 : acc_ff;
      if (!ctrl.acc_en) begin
         acc_in = acc_ff;
      end else if (ctrl.acc_sub) begin
         acc_in = base - addend;
      end else begin
         acc_in = base + addend;
      end
   end

   // floor shift, then saturate to the sample width
   always_comb begin
      qnt   = QNT_W'(acc_ff >>> COEF_FRAC_BITS);
      ovf   = (qnt[QNT_W-1:SAMPLE_BITS-1] != {(QNT_W-SAMPLE_BITS+1){qnt[QNT_W-1]}});
      y_sat = ovf ? {qnt[QNT_W-1], {(SAMPLE_BITS-1){~qnt[QNT_W-1]}}}
                  : qnt[SAMPLE_BITS-1:0];
   end

   always_comb begin
      x_cur_in = x_cur_ff;
      if (ctrl.load) begin
         x_cur_in = sample_in;
      end else if (ctrl.wb) begin
         x_cur_in = y_sat;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      x_cur_ff <= x_cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clr_all) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            xh1_ff[b] <= '0;
            xh2_ff[b] <= '0;
            yh1_ff[b] <= '0;
            yh2_ff[b] <= '0;
         end
      end else if (ctrl.clr_band) begin
         xh1_ff[ctrl.band] <= '0;
         xh2_ff[ctrl.band] <= '0;
         yh1_ff[ctrl.band] <= '0;
         yh2_ff[ctrl.band] <= '0;
      end else if (ctrl.wb) begin
         xh2_ff[ctrl.band] <= xh1_ff[ctrl.band];
         xh1_ff[ctrl.band] <= x_cur_ff;
         yh2_ff[ctrl.band] <= yh1_ff[ctrl.band];
         yh1_ff[ctrl.band] <= y_sat;
      end
   end

   assign sample_out = x_cur_ff;

endmodule

@@ src/stereo_biquad_cascade_eq_top.sv @@
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_eq_top
// Five-band stereo equaliser built from cascaded direct-form-1 biquads.
// ----------------------------------------------------------------------------
// Channels: req_bus takes items of three kinds. A sample item (mode 0) carries
// a stereo pair and yields one item on rsp_bus. A coefficient write (mode 1)
// stores one Q3.23 coefficient and clears that band's history; a clear item
// (mode 2) zeroes all history. Neither yields a result, and both finish in
// the cycle they are accepted. csr_bus writes eq_enable (index 0) and
// band_enable_mask (index 1); it is always ready.
// Timing: the left and right lanes run side by side, each with one
// multiplier stepped over the five taps of a band. A sample item visits each
// enabled band in turn (select, five multiply taps, drain, write back) and
// skips disabled bands; the block takes no new item until the result shows
// on rsp_bus, which happens in the same cycle as the block is ready again.
// Stalls: the result sits in an output register. If it has not been taken
// when the next result is done, the block holds that result internally and
// stops taking items until the register frees.
// Reset: coefficients return to pass-through (b0 = 1.0), all history is zeroed,
// the equaliser and all bands are enabled, and no result is pending.
// ----------------------------------------------------------------------------
module stereo_biquad_cascade_eq_top (
   input logic         clock,
   input logic         reset,
   sbqeq_req_if.sink   req_bus,
   sbqeq_rsp_if.source rsp_bus,
   sbqeq_csr_if.sink   csr_bus
);
   import sbqeq_pkg::*;

   sbqeq_state_type      state_ff, state_in;
   logic [BCNT_W-1:0]    band_ff, band_in;
   logic [TAP_W-1:0]     tap_ff, tap_in;
   logic                 eq_enable_ff;
   logic [MASK_BITS-1:0] band_mask_ff;
   logic signed [COEF_BITS-1:0] coef_ff [NUM_BANDS][NCOEF];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;

   sbqeq_lane_ctrl_type           ctrl;
   logic                          req_take;
   logic                          coef_wr;
   logic                          band_on;
   logic                          load_out;
   logic signed [COEF_BITS-1:0]   coef_rd;
   logic signed [SAMPLE_BITS-1:0] left_y, right_y;

   assign req_take = req_bus.valid && req_bus.ready;
   assign coef_wr  = req_take && (req_bus.mode == MODE_COEF)
                  && (32'(req_bus.band_index) < NUM_BANDS)
                  && (32'(req_bus.coef_select) < NCOEF);

   always_comb begin
      band_on = 1'b0;
      for (int i = 0; i < MASK_BITS; i++) begin
         if (band_ff == BCNT_W'(i)) begin
            band_on = band_mask_ff[i];
         end
      end
   end

   assign coef_rd = coef_ff[band_ff[BAND_W-1:0]][tap_ff];

   // sequencer: visit bands in order, five taps then drain and write back for each enabled band
   always_comb begin
      state_in       = state_ff;
      band_in        = band_ff;
      tap_in         = tap_ff;
      load_out       = 1'b0;
      ctrl           = '0;
      ctrl.band      = band_ff[BAND_W-1:0];
      ctrl.tap       = tap_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_bus.mode)
                  MODE_SAMPLE: begin
                     ctrl.load = 1'b1;
                     band_in   = '0;
                     state_in  = S_SEL;
                  end
                  MODE_COEF: begin
                     ctrl.clr_band = coef_wr;
                     ctrl.band     = BAND_W'(req_bus.band_index);
                  end
                  MODE_CLEAR: begin
                     ctrl.clr_all = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_SEL: begin
            if (band_ff == BCNT_W'(NUM_BANDS)) begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  load_out = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (eq_enable_ff && band_on) begin
               tap_in   = TAP_B0;
               state_in = S_MAC;
            end else begin
               band_in = band_ff + 1'b1;
            end
         end
         S_MAC: begin
            // accumulate the previous tap's product while this one multiplies
            if (tap_ff != TAP_B0) begin
               ctrl.acc_en    = 1'b1;
               ctrl.acc_first = (tap_ff == TAP_B1);
               ctrl.acc_sub   = (tap_ff == TAP_A2);
            end
            if (tap_ff == TAP_A2) begin
               state_in = S_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            ctrl.acc_en  = 1'b1;
            ctrl.acc_sub = 1'b1;
            state_in     = S_WB;
         end
         S_WB: begin
            ctrl.wb  = 1'b1;
            band_in  = band_ff + 1'b1;
            state_in = S_SEL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         band_ff  <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         tap_ff   <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            for (int k = 0; k < NCOEF; k++) begin
               coef_ff[b][k] <= '0;
            end
            coef_ff[b][TAP_B0] <= COEF_BITS'(1) << COEF_FRAC_BITS;
         end
      end else if (coef_wr) begin
         coef_ff[BAND_W'(req_bus.band_index)][req_bus.coef_select] <= req_bus.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_enable_ff <= 1'b1;
         band_mask_ff <= '1;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.reg_index)
            REG_EQ_ENABLE: eq_enable_ff <= csr_bus.wdata[0];
            REG_BAND_MASK: band_mask_ff <= csr_bus.wdata[MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == S_IDLE);

   sbqeq_lane u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample_in  (req_bus.left_in),
      .coef       (coef_rd),
      .sample_out (left_y)
   );

   sbqeq_lane u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample_in  (req_bus.right_in),
      .coef       (coef_rd),
      .sample_out (right_y)
   );

   // merge both lanes into the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         left_ff  <= left_y;
         right_ff <= right_y;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = left_ff;
   assign rsp_bus.right_out = right_ff;

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MAC |-> tap_ff <= TAP_A2)
      else $error("tap counter beyond last coefficient");

   a_band_range: assert property (@(posedge clock) disable iff (reset)
      band_ff <= BCNT_W'(NUM_BANDS))
      else $error("band counter beyond last band");

   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      req_take && req_bus.mode == MODE_SAMPLE |=> state_ff == S_SEL && band_ff == '0)
      else $error("sample item did not start at the first band");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_SEL && band_ff == BCNT_W'(NUM_BANDS)))
      else $error("result raised before the cascade finished");

endmodule

@@ test/sbqeq_eq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbqeq_eq_checker
// Watches the request, response and register channels of the equaliser,
// predicts every stereo result with its own cascade of biquads and compares
// each response item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sbqeq_eq_checker (
   input  logic        clock,
   input  logic        reset,
   sbqeq_req_if        req_bus,
   sbqeq_rsp_if        rsp_bus,
   sbqeq_csr_if        csr_bus,
   output int          mismatch_count,
   output int          pairs_pending
);
   import sbqeq_pkg::*;

   localparam longint SAMP_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMP_MIN   = -SAMP_MAX - 1;
   localparam int     REPORT_CAP = 100;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } stereo_pair_type;

   logic signed [COEF_BITS-1:0]   coef_tbl [NUM_BANDS][NCOEF];
   logic signed [SAMPLE_BITS-1:0] x_hist   [NUM_BANDS][2][2];
   logic signed [SAMPLE_BITS-1:0] y_hist   [NUM_BANDS][2][2];
   logic                          eq_on;
   logic [MASK_BITS-1:0]          band_on;
   stereo_pair_type               expected_pairs [$];

   function automatic void clear_band_history(int band);
      for (int ch = 0; ch < 2; ch++) begin
         x_hist[band][ch][0] = '0;
         x_hist[band][ch][1] = '0;
         y_hist[band][ch][0] = '0;
         y_hist[band][ch][1] = '0;
      end
   endfunction

   function automatic void restore_reset_state();
      eq_on   = 1'b1;
      band_on = '1;
      for (int b = 0; b < NUM_BANDS; b++) begin
         for (int k = 0; k < NCOEF; k++)
            coef_tbl[b][k] = '0;
         coef_tbl[b][TAP_B0] = COEF_BITS'(longint'(1) << COEF_FRAC_BITS);
         clear_band_history(b);
      end
   endfunction

   // one direct-form-1 section on one channel; products summed exactly
   function automatic logic signed [SAMPLE_BITS-1:0] biquad_step(
      int band, int ch, logic signed [SAMPLE_BITS-1:0] x);
      longint acc;
      longint y;
      acc = longint'(coef_tbl[band][TAP_B0]) * longint'(x)
          + longint'(coef_tbl[band][TAP_B1]) * longint'(x_hist[band][ch][0])
          + longint'(coef_tbl[band][TAP_B2]) * longint'(x_hist[band][ch][1])
          - longint'(coef_tbl[band][TAP_A1]) * longint'(y_hist[band][ch][0])
          - longint'(coef_tbl[band][TAP_A2]) * longint'(y_hist[band][ch][1]);
      y = acc >>> COEF_FRAC_BITS;
      if (y > SAMP_MAX)
         y = SAMP_MAX;
      else if (y < SAMP_MIN)
         y = SAMP_MIN;
      x_hist[band][ch][1] = x_hist[band][ch][0];
      x_hist[band][ch][0] = x;
      y_hist[band][ch][1] = y_hist[band][ch][0];
      y_hist[band][ch][0] = SAMPLE_BITS'(y);
      return SAMPLE_BITS'(y);
   endfunction

   function automatic stereo_pair_type equalise_pair(
      logic signed [SAMPLE_BITS-1:0] l_in, logic signed [SAMPLE_BITS-1:0] r_in);
      stereo_pair_type res;
      res.left  = l_in;
      res.right = r_in;
      if (eq_on) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            if (band_on[b]) begin
               res.left  = biquad_step(b, 0, res.left);
               res.right = biquad_step(b, 1, res.right);
            end
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic signed [SAMPLE_BITS-1:0] want,
                              input logic signed [SAMPLE_BITS-1:0] got);
      if (got !== want) begin
         // keep the log readable when everything goes wrong
         if (mismatch_count < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      stereo_pair_type want;
      if (reset) begin
         restore_reset_state();
         expected_pairs.delete();
      end else begin
         // retire the oldest prediction before this edge's request adds one
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pairs.size() == 0) begin
               if (mismatch_count < REPORT_CAP)
                  $display("%0t: unexpected result, expected none, actual %0d / %0d",
                           $time, rsp_bus.left_out, rsp_bus.right_out);
               mismatch_count++;
            end else begin
               want = expected_pairs.pop_front();
               check_field("left_out", want.left, rsp_bus.left_out);
               check_field("right_out", want.right, rsp_bus.right_out);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.mode)
               MODE_SAMPLE: begin
                  expected_pairs.push_back(equalise_pair(req_bus.left_in, req_bus.right_in));
               end
               MODE_COEF: begin
                  if (req_bus.band_index < NUM_BANDS && req_bus.coef_select < NCOEF) begin
                     coef_tbl[req_bus.band_index][req_bus.coef_select] = req_bus.coef_value;
                     clear_band_history(int'(req_bus.band_index));
                  end
               end
               MODE_CLEAR: begin
                  for (int b = 0; b < NUM_BANDS; b++)
                     clear_band_history(b);
               end
               default: ;
            endcase
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               REG_EQ_ENABLE: eq_on = csr_bus.wdata[0];
               REG_BAND_MASK: band_on = csr_bus.wdata[MASK_BITS-1:0];
               default: ;
            endcase
         end
      end
      pairs_pending = expected_pairs.size();
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the stereo equaliser with directed and random items: samples at the
// range extremes, coefficient writes to every band and tap, history clears,
// ignored items and register settings, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
   import sbqeq_pkg::*;

   localparam int         ITEM_TARGET   = 1700;
   localparam int         CYCLE_LIMIT   = 2000000;
   localparam int         SETTLE_CYCLES = 64;
   localparam int         UNITY         = 1 << COEF_FRAC_BITS;
   localparam int         COEF_MAX      = (1 << (COEF_BITS - 1)) - 1;
   localparam int         COEF_MIN      = -COEF_MAX - 1;
   localparam int         SAMP_MAX      = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int         SAMP_MIN      = -SAMP_MAX - 1;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   logic clock;
   logic reset;
   bit   idle_on = 1'b1;
   int   items_sent;
   int   cycle_count;
   int   mismatch_count;
   int   pairs_pending;

   sbqeq_req_if req_bus ();
   sbqeq_rsp_if rsp_bus ();
   sbqeq_csr_if csr_bus ();

   stereo_biquad_cascade_eq_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sbqeq_eq_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .pairs_pending  (pairs_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: short stalls, now and then one long enough to back up the block
   initial begin : rsp_pacing
      int stall;
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(99) < 12) begin
            stall = ($urandom_range(29) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 3);
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
      end
   end

   function automatic int rand_sample();
      case ($urandom_range(3))
         0: return $signed($urandom) >>> (32 - SAMPLE_BITS);
         1: return ($urandom_range(1) == 1) ? SAMP_MAX : SAMP_MIN;
         default: return $signed($urandom) >>> $urandom_range(33 - SAMPLE_BITS, 31);
      endcase
   endfunction

   function automatic int coef_near(int centre, int spread);
      int off;
      off = int'($urandom_range(2 * spread)) - spread;
      return centre + off;
   endfunction

   task automatic send_req(input logic [1:0] mode, input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r, input logic [2:0] band,
                           input logic [2:0] sel, input logic signed [COEF_BITS-1:0] coef);
      if (idle_on && $urandom_range(99) < 12) begin
         req_bus.valid = 1'b0;
         repeat (($urandom_range(3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 4))
            @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.mode        = mode;
      req_bus.left_in     = l;
      req_bus.right_in    = r;
      req_bus.band_index  = band;
      req_bus.coef_select = sel;
      req_bus.coef_value  = coef;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (mode == MODE_SAMPLE || mode == MODE_CLEAR ||
          (mode == MODE_COEF && band < NUM_BANDS && sel < NCOEF))
         items_sent++;
   endtask

   task automatic send_pair(input int l, input int r);
      send_req(MODE_SAMPLE, SAMPLE_BITS'(l), SAMPLE_BITS'(r), 3'($urandom), 3'($urandom),
               COEF_BITS'($urandom));
   endtask

   task automatic write_coef(input int band, input int sel, input int value);
      send_req(MODE_COEF, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 3'(band), 3'(sel),
               COEF_BITS'(value));
   endtask

   task automatic send_clear();
      send_req(MODE_CLEAR, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 3'($urandom),
               3'($urandom), COEF_BITS'($urandom));
   endtask

   // hold off until every result is back and the block has surely gone quiet
   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (pairs_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid     = 1'b1;
      csr_bus.reg_index = idx;
      csr_bus.wdata     = data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic reconfigure(input logic en, input logic [MASK_BITS-1:0] mask);
      wait_idle();
      write_csr(REG_EQ_ENABLE, {(CSR_DATA_W-1)'($urandom), en});
      write_csr(REG_BAND_MASK, {(CSR_DATA_W-MASK_BITS)'($urandom), mask});
      if ($urandom_range(3) == 0)
         write_csr(CSR_IDX_W'($urandom_range(2, (1 << CSR_IDX_W) - 1)), CSR_DATA_W'($urandom));
   endtask

   task automatic program_band(input int band, input bit wild);
      logic [TAP_W-1:0] sel;
      int               value;
      for (int k = 0; k < NCOEF; k++) begin
         sel = TAP_W'(k);
         if (wild)
            value = int'($urandom);
         else begin
            case (sel)
               TAP_B0:  value = coef_near(UNITY, 1 << 22);
               TAP_B1:  value = coef_near(0, 1 << 23);
               TAP_B2:  value = coef_near(0, 1 << 22);
               TAP_A1:  value = coef_near(0, 1 << 24);
               default: value = coef_near(0, 3 << 21);
            endcase
         end
         write_coef(band, sel, value);
      end
   endtask

   initial begin : stimulus
      int pick;
      req_bus.valid       = 1'b0;
      req_bus.mode        = MODE_SAMPLE;
      req_bus.left_in     = '0;
      req_bus.right_in    = '0;
      req_bus.band_index  = '0;
      req_bus.coef_select = '0;
      req_bus.coef_value  = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.reg_index   = REG_EQ_ENABLE;
      csr_bus.wdata       = '0;
      reset               = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // pass-through at reset, then gain extremes with saturation and floor rounding
      send_pair(SAMP_MAX, SAMP_MIN);
      send_pair(0, -1);
      write_coef(0, TAP_B0, COEF_MAX);
      send_pair(SAMP_MAX, SAMP_MIN);
      write_coef(0, TAP_B0, COEF_MIN);
      send_pair(SAMP_MAX, SAMP_MIN);
      write_coef(0, TAP_B0, 1);
      send_pair(1, -1);
      write_coef(0, TAP_B0, UNITY);
      write_coef(1, TAP_B1, UNITY / 2);
      write_coef(2, TAP_B2, -UNITY / 4);
      write_coef(3, TAP_A1, -UNITY / 2);
      write_coef(4, TAP_A2, UNITY / 4);
      send_pair(1000000, -1000000);
      send_pair(SAMP_MAX, SAMP_MIN);
      send_pair(12345, -54321);
      send_clear();
      send_pair(SAMP_MAX, 0);
      // ignored: band out of range, tap out of range, unused mode
      write_coef(NUM_BANDS, TAP_B0, 0);
      write_coef(2, 7, COEF_MAX);
      send_req(MODE_UNUSED, SAMPLE_BITS'(SAMP_MAX), SAMPLE_BITS'(SAMP_MIN), 3'd7, 3'd7,
               COEF_BITS'(COEF_MIN));
      send_pair(-777, 777);
      reconfigure(1'b0, '1);
      send_pair(SAMP_MIN, SAMP_MAX);
      reconfigure(1'b1, '0);
      send_pair(4242, -4242);
      reconfigure(1'b1, 5'b10101);
      send_pair(SAMP_MAX, SAMP_MIN);
      send_pair(99, -99);
      reconfigure(1'b1, '1);

      while (items_sent < ITEM_TARGET) begin
         idle_on = !(items_sent >= 500 && items_sent < 800);
         pick = $urandom_range(99);
         if (pick < 6) begin
            case ($urandom_range(3))
               0:       reconfigure(1'b1, '1);
               1:       reconfigure(1'b0, MASK_BITS'($urandom));
               2:       reconfigure(1'b1, '0);
               default: reconfigure(1'b1, MASK_BITS'($urandom));
            endcase
         end else if (pick < 11) begin
            case ($urandom_range(2))
               0: send_req(MODE_UNUSED, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                           3'($urandom), 3'($urandom), COEF_BITS'($urandom));
               1: write_coef($urandom_range(NUM_BANDS, 7), $urandom_range(7), int'($urandom));
               default: write_coef($urandom_range(NUM_BANDS - 1), $urandom_range(NCOEF, 7),
                                   int'($urandom));
            endcase
         end else if (pick < 15) begin
            send_clear();
         end else if (pick < 18) begin
            wait_idle();
         end else if (pick < 24) begin
            program_band($urandom_range(NUM_BANDS - 1), 1'b1);
            repeat ($urandom_range(2, 8)) send_pair(rand_sample(), rand_sample());
         end else if (pick < 30) begin
            write_coef($urandom_range(NUM_BANDS - 1), $urandom_range(NCOEF - 1),
                       coef_near(0, UNITY));
         end else if (pick < 55) begin
            program_band($urandom_range(NUM_BANDS - 1), 1'b0);
            repeat ($urandom_range(4, 24)) send_pair(rand_sample(), rand_sample());
         end else begin
            repeat ($urandom_range(4, 24)) send_pair(rand_sample(), rand_sample());
         end
      end

      idle_on = 1'b1;
      wait_idle();
      if (mismatch_count == 0 && pairs_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/sbqeq_pkg.sv
src/sbqeq_req_if.sv
src/sbqeq_rsp_if.sv
src/sbqeq_csr_if.sv
src/sbqeq_lane.sv
src/stereo_biquad_cascade_eq_top.sv
test/sbqeq_eq_checker.sv
test/tb_top.sv
